>>> sv/pss_pkg.sv
package pss_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_ITEMS_DEF  = 128;
    localparam int VALUE_BITS_DEF = 16;

    // The target register width is fixed.
    localparam int TARGET_BITS = 17;

endpackage

>>> sv/pss_if.sv
// Input channel: one list element per beat.
interface pss_in_if
    import pss_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] item_value;
    logic                  last_item;

    modport source (output valid, output item_value, output last_item, input ready);
    modport sink   (input valid, input item_value, input last_item, output ready);
endinterface

// Output channel: one search result per beat.
interface pss_out_if
    import pss_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  found;
    logic [VALUE_BITS-1:0] smaller_value;
    logic [VALUE_BITS-1:0] larger_value;

    modport source (output valid, output found, output smaller_value,
                    output larger_value, input ready);
    modport sink   (input valid, input found, input smaller_value,
                    input larger_value, output ready);
endinterface

>>> sv/pair_sum_search.sv
// Pair sum search. Load a list of unsigned values, one per input beat, into an
// on-chip memory of MAX_ITEMS entries; the beat with last_item set closes the
// list (beats beyond MAX_ITEMS are dropped, but a dropped beat flagged last
// still closes the list). The block then scans index pairs i<j, i outer and j
// inner, both ascending, and returns one result beat for the first pair whose
// later value is below target_sum and whose two values add up to target_sum
// exactly: found=1 with the two values ordered smaller first. Without such a
// pair, found=0 and both values are zero. The scan runs over the memory's
// single read port, one pair per cycle, plus an S_RDI and an S_LDA step to
// fetch each new outer value. Input beats are taken only while loading; a new
// list may load while a result beat still waits to be taken. Write target_sum
// through cfg_wr_en / cfg_wr_data only while the block is idle. Reset clears
// the list and target_sum; no clearing pass is needed.
module pair_sum_search
    import pss_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [TARGET_BITS-1:0] cfg_wr_data,
    pss_in_if.sink                 in_item,
    pss_out_if.source              out_result
);

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int CMP_W = (VALUE_BITS + 1 > TARGET_BITS) ? VALUE_BITS + 1 : TARGET_BITS;

    // Sequencer codes.
    localparam logic [2:0] S_LOAD = 3'd0; // take list beats
    localparam logic [2:0] S_RDI  = 3'd1; // read the outer value
    localparam logic [2:0] S_LDA  = 3'd2; // latch outer value, read first inner
    localparam logic [2:0] S_CMP  = 3'd3; // compare one pair per cycle
    localparam logic [2:0] S_FIN  = 3'd4; // hand the result to the output stage

    logic [2:0]             state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       i_reg, i_next;
    logic [IDX_W-1:0]       j_reg, j_next;
    logic [TARGET_BITS-1:0] target_reg;
    logic [VALUE_BITS-1:0]  a_reg, a_next;

    logic                   res_found_reg, res_found_next;
    logic [VALUE_BITS-1:0]  res_lo_reg, res_lo_next;
    logic [VALUE_BITS-1:0]  res_hi_reg, res_hi_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_found_reg, out_found_next;
    logic [VALUE_BITS-1:0]  out_lo_reg, out_lo_next;
    logic [VALUE_BITS-1:0]  out_hi_reg, out_hi_next;

    // Value store: one write port, one registered read port.
    logic [VALUE_BITS-1:0]  mem [MAX_ITEMS];
    logic [VALUE_BITS-1:0]  rd_data;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;

    logic                   in_beat;
    logic                   out_free;
    logic                   store_room;
    logic [CNT_W-1:0]       loaded_count;
    logic [CMP_W-1:0]       a_ext;
    logic [CMP_W-1:0]       b_ext;
    logic [CMP_W-1:0]       t_ext;
    logic                   pair_hit;
    logic                   j_more;
    logic                   i_more;

    assign in_item.ready = (state_reg == S_LOAD);
    assign in_beat       = in_item.valid && in_item.ready;
    assign store_room    = (count_reg < CNT_W'(MAX_ITEMS));
    assign wr_en         = in_beat && store_room;
    assign loaded_count  = store_room ? count_reg + CNT_W'(1) : count_reg;

    // Output slot can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || out_result.ready;

    // Pair check: rd_data holds the inner value while scanning.
    assign a_ext    = CMP_W'(a_reg);
    assign b_ext    = CMP_W'(rd_data);
    assign t_ext    = CMP_W'(target_reg);
    assign pair_hit = (b_ext < t_ext) && (a_ext + b_ext == t_ext);
    assign j_more   = (CNT_W'(j_reg) + CNT_W'(1)) < count_reg;
    assign i_more   = (CNT_W'(i_reg) + CNT_W'(2)) < count_reg;

    always_comb
    begin
        case (state_reg)
            S_RDI:   rd_addr = i_reg;
            S_LDA:   rd_addr = i_reg + IDX_W'(1);
            S_CMP:   rd_addr = j_reg + IDX_W'(1);
            default: rd_addr = i_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= in_item.item_value;
        end
        rd_data <= mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        a_next         = a_reg;
        res_found_next = res_found_reg;
        res_lo_next    = res_lo_reg;
        res_hi_next    = res_hi_reg;
        out_valid_next = out_valid_reg && !out_result.ready;
        out_found_next = out_found_reg;
        out_lo_next    = out_lo_reg;
        out_hi_next    = out_hi_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (in_beat)
                begin
                    count_next = loaded_count;
                    if (in_item.last_item)
                    begin
                        i_next         = '0;
                        res_found_next = 1'b0;
                        res_lo_next    = '0;
                        res_hi_next    = '0;
                        // Fewer than two values: nothing to pair.
                        state_next = (loaded_count < CNT_W'(2)) ? S_FIN : S_RDI;
                    end
                end
            end
            S_RDI:
            begin
                state_next = S_LDA;
            end
            S_LDA:
            begin
                a_next     = rd_data;
                j_next     = i_reg + IDX_W'(1);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (pair_hit)
                begin
                    res_found_next = 1'b1;
                    res_lo_next    = (a_reg <= rd_data) ? a_reg : rd_data;
                    res_hi_next    = (a_reg <= rd_data) ? rd_data : a_reg;
                    state_next     = S_FIN;
                end
                else if (j_more)
                begin
                    j_next = j_reg + IDX_W'(1);
                end
                else if (i_more)
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = S_RDI;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_lo_next    = res_lo_reg;
                    out_hi_next    = res_hi_reg;
                    count_next     = '0;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            target_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                target_reg <= cfg_wr_data;
            end
        end
    end

    // Payload and scan registers: no reset needed.
    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        j_reg         <= j_next;
        a_reg         <= a_next;
        res_found_reg <= res_found_next;
        res_lo_reg    <= res_lo_next;
        res_hi_reg    <= res_hi_next;
        out_found_reg <= out_found_next;
        out_lo_reg    <= out_lo_next;
        out_hi_reg    <= out_hi_next;
    end

    assign out_result.valid         = out_valid_reg;
    assign out_result.found         = out_found_reg;
    assign out_result.smaller_value = out_lo_reg;
    assign out_result.larger_value  = out_hi_reg;

`ifndef NO_ASSERTIONS
    // The fill count never passes the store depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("item count exceeds store depth");

    // Inner index stays after the outer one and inside the list while scanning.
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (j_reg > i_reg) && (CNT_W'(j_reg) < count_reg))
        else $error("scan index out of range");

    // A scan only runs over a list of at least two values.
    a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDI || state_reg == S_LDA || state_reg == S_CMP)
            |-> (count_reg >= CNT_W'(2)))
        else $error("scan over a list shorter than two");

    // A new result beat appears only right after the finish step.
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result beat without a finished search");
`endif

endmodule

>>> tb/pair_sum_search_test.sv
`timescale 1ns / 1ps

module pair_sum_search_test;
    import pss_pkg::*;

    localparam int VBITS      = VALUE_BITS_DEF;
    localparam int DEPTH      = MAX_ITEMS_DEF;
    localparam int VALUE_MAX  = (1 << VBITS) - 1;
    localparam int TARGET_MAX = (1 << TARGET_BITS) - 1;

    // One list element as it waits to be sent.
    typedef struct packed {
        logic [VBITS-1:0] value;
        logic             last;
    } list_item_t;

    // One search outcome, in the field order of the result channel.
    typedef struct packed {
        logic             found;
        logic [VBITS-1:0] smaller;
        logic [VBITS-1:0] larger;
    } pair_result_t;

    // How a random list is filled.
    typedef enum {
        LIST_PLANTED,   // random values with one pair that reaches the target
        LIST_POOL,      // values from a few candidates, so many pairs compete
        LIST_NOISE      // plain random values
    } list_style_t;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [TARGET_BITS-1:0] cfg_wr_data = '0;

    // Channel drive, known from time zero.
    logic             send_valid = 1'b0;
    logic [VBITS-1:0] send_value = '0;
    logic             send_last  = 1'b0;
    logic             take_ready = 1'b0;

    int send_idle_pct = 15;
    int take_idle_pct = 81;
    int fail_count    = 0;

    list_item_t   item_q[$];          // elements not yet accepted by the block
    pair_result_t pair_expect_q[$];   // search outcomes not yet returned

    // Mirror of the block: stored list, its length and the target sum.
    logic [VBITS-1:0]       list_mem[DEPTH];
    int                     list_len   = 0;
    logic [TARGET_BITS-1:0] sum_target = '0;

    pss_in_if  #(.VALUE_BITS(VBITS)) in_ch();
    pss_out_if #(.VALUE_BITS(VBITS)) out_ch();

    assign in_ch.valid      = send_valid;
    assign in_ch.item_value = send_value;
    assign in_ch.last_item  = send_last;
    assign out_ch.ready     = take_ready;

    pair_sum_search #(
        .MAX_ITEMS  (DEPTH),
        .VALUE_BITS (VBITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_item     (in_ch),
        .out_result  (out_ch)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Store one accepted element; on the closing element scan pairs i<j in
    // row order and queue the first one whose later value is below the target
    // and whose sum hits it exactly. Elements past a full store are dropped,
    // but a dropped closing element still starts the scan.
    function automatic void load_and_search(logic [VBITS-1:0] value, logic last);
        pair_result_t           res;
        logic [TARGET_BITS-1:0] pair_sum;
        int                     i;
        int                     j;
        if (list_len < DEPTH)
        begin
            list_mem[list_len] = value;
            list_len++;
        end
        if (last)
        begin
            res = '0;
            for (i = 0; i + 1 < list_len && !res.found; i++)
            begin
                for (j = i + 1; j < list_len && !res.found; j++)
                begin
                    pair_sum = list_mem[i] + list_mem[j];
                    if (list_mem[j] < sum_target && pair_sum == sum_target)
                    begin
                        res.found   = 1'b1;
                        res.smaller = (list_mem[i] <= list_mem[j]) ? list_mem[i] : list_mem[j];
                        res.larger  = (list_mem[i] <= list_mem[j]) ? list_mem[j] : list_mem[i];
                    end
                end
            end
            pair_expect_q.push_back(res);
            list_len = 0;
        end
    endfunction

    // Driver: retire the beat the block took, then offer the next pending
    // element unless this cycle idles. Hold the current beat while stalled.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            send_valid <= 1'b0;
        end
        else
        begin
            if (send_valid && in_ch.ready)
            begin
                load_and_search(send_value, send_last);
                item_q.delete(0);
            end
            if (!send_valid || in_ch.ready)
            begin
                if (item_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    send_valid <= 1'b1;
                    send_value <= item_q[0].value;
                    send_last  <= item_q[0].last;
                end
                else
                begin
                    send_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result beat with the oldest pending outcome,
    // then pick the ready level for the next cycle.
    always @(posedge clk)
    begin : result_check
        pair_result_t want;
        if (!rst_n)
        begin
            take_ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && take_ready)
            begin
                if (pair_expect_q.size() == 0)
                begin
                    $error("unexpected result beat: found %0d smaller %0d larger %0d",
                           out_ch.found, out_ch.smaller_value, out_ch.larger_value);
                    fail_count++;
                end
                else
                begin
                    want = pair_expect_q.pop_front();
                    if (out_ch.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, out_ch.found);
                        fail_count++;
                    end
                    if (out_ch.smaller_value !== want.smaller)
                    begin
                        $error("smaller_value: expected %0d, got %0d",
                               want.smaller, out_ch.smaller_value);
                        fail_count++;
                    end
                    if (out_ch.larger_value !== want.larger)
                    begin
                        $error("larger_value: expected %0d, got %0d",
                               want.larger, out_ch.larger_value);
                        fail_count++;
                    end
                end
            end
            take_ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    task automatic push_item(int value, bit last);
        list_item_t it;
        it.value = value[VBITS-1:0];
        it.last  = last;
        item_q.push_back(it);
    endtask

    // Hold until every element went in and every outcome came back, then
    // let the block settle.
    task automatic wait_drained();
        while (item_q.size() != 0 || pair_expect_q.size() != 0 || send_valid)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Write the target only with the block idle; the mirror follows at once.
    task automatic write_target(int value);
        wait_drained();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[TARGET_BITS-1:0];
        sum_target   = value[TARGET_BITS-1:0];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Queue one list of n elements, the last one flagged.
    task automatic queue_list(int n, list_style_t style);
        int               vals[$];
        int               pool[4];
        int               lo;
        int               hi;
        int               x;
        int               pi;
        int               pj;
        int               k;
        lo = (int'(sum_target) > VALUE_MAX) ? int'(sum_target) - VALUE_MAX : 0;
        hi = (int'(sum_target) < VALUE_MAX) ? int'(sum_target) : VALUE_MAX;
        // A pair of stored values can reach the target only when lo <= hi.
        x = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(VALUE_MAX, 0);
        pool[0] = x;
        pool[1] = (int'(sum_target) - x) & VALUE_MAX;
        pool[2] = 0;
        pool[3] = int'(sum_target) & VALUE_MAX;
        for (k = 0; k < n; k++)
        begin
            if (style == LIST_POOL)
                vals.push_back(pool[$urandom_range(3, 0)]);
            else
                vals.push_back($urandom_range(VALUE_MAX, 0));
        end
        // Plant the pair in either order: with a zero partner placed first,
        // the later value equals the target and the pair must be skipped.
        if (style == LIST_PLANTED && n >= 2 && lo <= hi)
        begin
            pi = $urandom_range(n - 2, 0);
            pj = $urandom_range(n - 1, pi + 1);
            if ($urandom_range(1, 0) == 1)
            begin
                vals[pi] = x;
                vals[pj] = int'(sum_target) - x;
            end
            else
            begin
                vals[pi] = int'(sum_target) - x;
                vals[pj] = x;
            end
        end
        for (k = 0; k < n; k++)
        begin
            push_item(vals[k], k == n - 1);
        end
    endtask

    initial
    begin
        int          phase;
        int          queued;
        int          n;
        int          r;
        int          tgt;
        list_style_t style;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Target zero after reset: nothing can match, not even two zeros,
        // since the later value is never below zero. Cover a single element.
        push_item(7, 1);
        push_item(0, 0);
        push_item(0, 1);

        write_target(100);
        push_item(30, 0);       // plain hit
        push_item(70, 1);
        push_item(70, 0);       // hit with the larger value first
        push_item(30, 1);
        push_item(100, 0);      // later value zero is below the target
        push_item(0, 1);
        push_item(0, 0);        // sum matches but later value equals target
        push_item(100, 1);
        push_item(50, 0);       // equal values
        push_item(50, 1);
        push_item(20, 0);       // row order: (20,80) wins over (10,90)
        push_item(10, 0);
        push_item(80, 0);
        push_item(90, 1);

        write_target(131070);   // largest reachable sum
        push_item(65535, 0);
        push_item(65535, 1);

        write_target(TARGET_MAX);   // out of reach of any two values
        push_item(65535, 0);
        push_item(65535, 0);
        push_item(1, 1);

        // Random part: three idling modes, four targets each.
        for (phase = 0; phase < 12; phase++)
        begin
            case (phase / 4)
                0:
                begin
                    send_idle_pct = 15;
                    take_idle_pct = 81;
                end
                1:
                begin
                    send_idle_pct = 81;
                    take_idle_pct = 15;
                end
                default:
                begin
                    send_idle_pct = 0;
                    take_idle_pct = 0;
                end
            endcase
            case (phase)
                0:       tgt = 1;
                1:       tgt = 65535;
                2:       tgt = 131070;
                4:       tgt = 65536;
                5:       tgt = 0;
                6:       tgt = 2;
                8:       tgt = TARGET_MAX;
                9:       tgt = 40000;
                default: tgt = $urandom_range(TARGET_MAX, 0);
            endcase
            write_target(tgt);

            // Once per idling mode, fill or overfill the store; the closing element
            // may land among the dropped ones.
            if (phase % 4 == 1)
                queue_list(DEPTH + $urandom_range(4, 0), LIST_PLANTED);

            queued = 0;
            while (queued < 60)
            begin
                r = $urandom_range(99);
                n = (r < 75) ? $urandom_range(8, 1) :
                    (r < 97) ? $urandom_range(32, 9) : $urandom_range(64, 33);
                r = $urandom_range(9);
                style = (r < 6) ? LIST_PLANTED : (r < 8) ? LIST_POOL : LIST_NOISE;
                queue_list(n, style);
                queued += n;
            end
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pair_expect_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
sv/pss_pkg.sv
sv/pss_if.sv
sv/pair_sum_search.sv
tb/pair_sum_search_test.sv
